[design/sctab_pkg.sv]
`default_nettype none
package sctab_pkg;

    // action codes
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_ADD    = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_LOOKUP_OK = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_REPLACED  = 3'd2,
        ST_NEG_TIME  = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // input word
    typedef struct packed {
        logic               action;
        logic signed [31:0] query_time;
        logic signed [31:0] control_value;
    } t_item;

    // result word
    typedef struct packed {
        logic signed [31:0] control_out;
        logic               found;
        logic [2:0]         status;
        logic [4:0]         entry_count;
    } t_result;

    // data handed from one cell to its right neighbor
    typedef struct packed {
        logic               valid;
        logic               pos;
        logic signed [31:0] tm;
        logic signed [31:0] ctrl;
    } t_link;

    // command broadcast to every cell
    typedef struct packed {
        logic               add_en;
        logic               dup;
        logic               full;
        logic signed [31:0] tm;
        logic signed [31:0] ctrl;
    } t_cell_cmd;

endpackage
`default_nettype wire

[design/sorted_control_schedule_table.sv]
`default_nettype none
// Schedule table of (time, control) entries kept sorted by time in a chain of
// TABLE_DEPTH cells; after reset it holds the single entry (0, 0). For each
// word, start is taken when busy is low, busy is high in the next
// cycle while every cell compares against the query and shifts or overwrites
// in place, and the result appears on o_result with o_valid high for exactly
// one cycle after that, when the next word may already be started. Results
// cannot be stalled; the receiver must take each one in its strobe cycle.
// Add words insert in time order or replace the control of an equal time;
// negative times are rejected and an add of a new time to a full table is
// dropped. entry_count reports the entries held, modulo 32.
module sorted_control_schedule_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire sctab_pkg::t_item    i_item,
    output logic                     o_valid,
    output sctab_pkg::t_result       o_result
);
    import sctab_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic                   r_busy;
    t_item                  r_item;
    logic                   r_valid;
    t_result                r_result;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    t_result                n_result;

    t_cell_cmd              w_cmd;
    t_link                  w_link [0:TABLE_DEPTH];
    logic                   w_le   [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_eq;
    logic [TABLE_DEPTH-1:0] w_hit;
    logic [TABLE_DEPTH-1:0] w_vld;
    logic                   w_neg;
    logic                   w_dup;
    logic                   w_full;
    logic signed [31:0]     w_sel;
    logic [31:0]            w_cnt_ext;

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // chain ends
    assign w_link[0]          = '0;
    assign w_le[TABLE_DEPTH]  = 1'b0;

    assign w_neg  = r_item.query_time < 0;
    assign w_dup  = |w_eq;
    assign w_full = w_link[TABLE_DEPTH].valid;

    assign w_cmd.add_en = r_busy && (r_item.action == ACT_ADD) && !w_neg;
    assign w_cmd.dup    = w_dup;
    assign w_cmd.full   = w_full;
    assign w_cmd.tm     = r_item.query_time;
    assign w_cmd.ctrl   = r_item.control_value;

    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            sctab_cell #(
                .HEAD (g == 0)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_left     (w_link[g]),
                .i_right_le (w_le[g+1]),
                .o_link     (w_link[g+1]),
                .o_le       (w_le[g]),
                .o_eq       (w_eq[g]),
                .o_hit      (w_hit[g])
            );
            assign w_vld[g] = w_link[g+1].valid;
        end
    endgenerate

    // pick the control of the one hitting cell
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (w_hit[k]) begin
                w_sel = w_sel | w_link[k+1].ctrl;
            end
        end
    end

    // build the result word and the next entry count
    always_comb begin
        n_count              = r_count;
        n_result.control_out = '0;
        n_result.found       = 1'b0;
        n_result.status      = ST_LOOKUP_OK;
        if (w_neg) begin
            n_result.status = ST_NEG_TIME;
        end else if (r_item.action == ACT_LOOKUP) begin
            n_result.found       = |w_hit;
            n_result.control_out = w_sel;
        end else if (w_dup) begin
            n_result.status = ST_REPLACED;
        end else if (w_full) begin
            n_result.status = ST_FULL;
        end else begin
            n_result.status = ST_INSERTED;
            n_count         = r_count + 1'b1;
        end
        w_cnt_ext            = 32'(n_count);
        n_result.entry_count = w_cnt_ext[4:0];
    end

    // control: take a word, work on it while busy, strobe the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= CW'(1);
        end else begin
            r_valid <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    // payload: hold the word and the result
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_item <= i_item;
        end
        if (r_busy) begin
            r_result <= n_result;
        end
    end

    // at most one cell ends the run of entries not after the query
    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(w_hit))
        else $error("more than one cell hit on lookup");

    // count tracks the occupied cells
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_vld) == 32'(r_count))
        else $error("entry count differs from occupied cells");

    // the head entry is never lost
    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_vld[0])
        else $error("head cell lost its entry");

    // a result follows exactly one busy cycle
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> (r_valid && !r_busy))
        else $error("result strobe missing after busy cycle");

endmodule
`default_nettype wire

[design/sctab_cell.sv]
`default_nettype none
module sctab_cell #(
    parameter bit HEAD = 1'b0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire sctab_pkg::t_cell_cmd  i_cmd,
    input  wire sctab_pkg::t_link      i_left,
    input  wire logic                  i_right_le,
    output sctab_pkg::t_link           o_link,
    output logic                       o_le,
    output logic                       o_eq,
    output logic                       o_hit
);
    import sctab_pkg::*;

    logic               r_valid;
    logic signed [31:0] r_tm;
    logic signed [31:0] r_ctrl;
    logic               n_valid;
    logic signed [31:0] n_tm;
    logic signed [31:0] n_ctrl;
    logic               w_pos;

    // compare the held entry against the query time
    assign o_le  = r_valid && (r_tm <= i_cmd.tm);
    assign o_eq  = r_valid && (r_tm == i_cmd.tm);
    assign w_pos = !r_valid || (r_tm >= i_cmd.tm);
    assign o_hit = o_le && !i_right_le;

    assign o_link.valid = r_valid;
    assign o_link.pos   = w_pos;
    assign o_link.tm    = r_tm;
    assign o_link.ctrl  = r_ctrl;

    // replace on a matching time, else shift right from the insert point
    always_comb begin
        n_valid = r_valid;
        n_tm    = r_tm;
        n_ctrl  = r_ctrl;
        if (i_cmd.add_en) begin
            if (i_cmd.dup) begin
                if (o_eq) begin
                    n_ctrl = i_cmd.ctrl;
                end
            end else if (!i_cmd.full && w_pos) begin
                if (i_left.pos) begin
                    n_valid = i_left.valid;
                    n_tm    = i_left.tm;
                    n_ctrl  = i_left.ctrl;
                end else begin
                    n_valid = 1'b1;
                    n_tm    = i_cmd.tm;
                    n_ctrl  = i_cmd.ctrl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= HEAD;
            r_tm    <= '0;
            r_ctrl  <= '0;
        end else begin
            r_valid <= n_valid;
            r_tm    <= n_tm;
            r_ctrl  <= n_ctrl;
        end
    end

endmodule
`default_nettype wire

[tb/sorted_control_schedule_table_test.sv]
`default_nettype none
module sorted_control_schedule_table_test;
    import sctab_pkg::*;

    localparam int SCHED_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MIX_WORDS    = 1100;
    localparam int IDLE_PERCENT = 27;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_item   i_item;
    logic    o_valid;
    t_result o_result;

    // schedule as the block should hold it, updated as each word is accepted
    logic signed [31:0] held_times [SCHED_DEPTH];
    logic signed [31:0] held_ctrls [SCHED_DEPTH];
    int                 held_count;

    t_result pending_answers [$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    logic    gaps_enabled = 1'b1;

    sorted_control_schedule_table #(
        .TABLE_DEPTH(SCHED_DEPTH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // compute the answer to one word and apply it to the held schedule
    function automatic t_result schedule_answer(input t_item w);
        t_result            r;
        logic signed [31:0] t;
        int                 n;
        int                 pos;
        r = '0;
        t = w.query_time;
        n = held_count;
        r.status = ST_LOOKUP_OK;
        if (t < 0) begin
            r.status = ST_NEG_TIME;
        end else if (w.action == ACT_LOOKUP) begin
            // entries are sorted, so the last one not after t wins
            for (int i = 0; i < n; i++) begin
                if (held_times[i] <= t) begin
                    r.found = 1'b1;
                    r.control_out = held_ctrls[i];
                end
            end
        end else begin
            pos = n;
            for (int i = 0; i < n; i++) begin
                if (held_times[i] >= t) begin
                    pos = i;
                    break;
                end
            end
            if (pos < n && held_times[pos] == t) begin
                held_ctrls[pos] = w.control_value;
                r.status = ST_REPLACED;
            end else if (n >= SCHED_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // open a slot at pos and shift the later entries right
                for (int i = n; i > pos; i--) begin
                    held_times[i] = held_times[i - 1];
                    held_ctrls[i] = held_ctrls[i - 1];
                end
                held_times[pos] = t;
                held_ctrls[pos] = w.control_value;
                held_count = n + 1;
                r.status = ST_INSERTED;
            end
        end
        r.entry_count = 5'(held_count);
        return r;
    endfunction

    // hold start low for a random number of cycles
    task automatic idle_sender();
        if (gaps_enabled) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
    endtask

    // present one word and wait until the block takes it
    task automatic issue_word(input logic act, input logic [31:0] tm, input logic [31:0] ctl);
        t_item w;
        logic  taken;
        w.action        = act;
        w.query_time    = tm;
        w.control_value = ctl;
        idle_sender();
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= w;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
                pending_answers.insert(pending_answers.size(), schedule_answer(w));
            end
        end
    endtask

    // pick a time, often close to held entry times to hit the boundaries
    function automatic logic [31:0] pick_time();
        logic [31:0] base;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                base = held_times[$urandom_range(held_count - 1)];
                return base + 32'($urandom_range(2)) - 32'd1;
            end
            4:       return 32'($urandom_range(32'h0008_0000));
            5:       return $urandom & 32'h7FFF_FFFF;
            6:       return $urandom | 32'h8000_0000;
            7: begin
                case ($urandom_range(3))
                    0:       return 32'h0000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'hFFFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // check each result word against the oldest pending answer
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, o_result);
                mismatch_count <= mismatch_count + 1;
            end else begin
                want = pending_answers.pop_front();
                if (o_result.control_out !== want.control_out
                        || o_result.found !== want.found
                        || o_result.status !== want.status
                        || o_result.entry_count !== want.entry_count) begin
                    $write("%0t: expected ctl=%h found=%b status=%0d count=%0d, ",
                           $time, want.control_out, want.found, want.status,
                           want.entry_count);
                    $display("got ctl=%h found=%b status=%0d count=%0d",
                             o_result.control_out, o_result.found,
                             o_result.status, o_result.entry_count);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    // extremes, negative times, replace of the reset entry, inserts out of time order
    task automatic test_directed();
        issue_word(ACT_LOOKUP, 32'h0000_0000, 32'hDEAD_BEEF);
        issue_word(ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_word(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        issue_word(ACT_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
        issue_word(ACT_ADD,    32'h8000_0000, 32'h1234_5678);
        issue_word(ACT_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF);
        issue_word(ACT_ADD,    32'h0000_0000, 32'h7FFF_FFFF);
        issue_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        issue_word(ACT_ADD,    32'h7FFF_FFFF, 32'h8000_0000);
        issue_word(ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        issue_word(ACT_LOOKUP, 32'h7FFF_FFFE, 32'h0000_0000);
        issue_word(ACT_ADD,    32'h0000_0001, 32'hFFFF_FFFF);
        issue_word(ACT_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        issue_word(ACT_ADD,    32'h0001_0000, 32'h0000_8000);
        issue_word(ACT_ADD,    32'h0000_8000, 32'h1234_5678);
        issue_word(ACT_LOOKUP, 32'h0000_7FFF, 32'h0000_0000);
        issue_word(ACT_LOOKUP, 32'h0000_FFFF, 32'h0000_0000);
        issue_word(ACT_ADD,    32'h0001_0000, 32'h0000_0000);
        issue_word(ACT_LOOKUP, 32'h0001_8000, 32'hFFFF_FFFF);
        issue_word(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    endtask

    // grow the schedule to full with lookups in between
    task automatic test_fill_schedule();
        while (held_count < SCHED_DEPTH) begin
            if ($urandom_range(99) < 60)
                issue_word(ACT_ADD, $urandom_range(3) == 0 ? $urandom & 32'h7FFF_FFFF
                           : pick_time(), $urandom);
            else
                issue_word(ACT_LOOKUP, pick_time(), $urandom);
        end
    endtask

    // lookups, replaces, adds to the full schedule and negative times
    task automatic test_random_mix();
        for (int k = 0; k < MIX_WORDS; k++) begin
            // run a long stretch back to back
            gaps_enabled = !(k >= 400 && k < 700);
            issue_word($urandom_range(99) < 55 ? ACT_LOOKUP : ACT_ADD, pick_time(), $urandom);
        end
        gaps_enabled = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        for (int i = 0; i < SCHED_DEPTH; i++) begin
            held_times[i] = '0;
            held_ctrls[i] = '0;
        end
        held_count = 1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_fill_schedule();
        test_random_mix();

        // drain the remaining answers, then allow for stray results
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_answers.size() > 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
